FILE: sv/deq_pkg.sv
// shared constants, codes and types of the double-ended queue
package deq_pkg;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned FILL_W     = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_PUSH_BACK  = 2'd0,
		REQ_PUSH_FRONT = 2'd1,
		REQ_POP_BACK   = 2'd2,
		REQ_POP_FRONT  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic                  push_back;
		logic                  push_front;
		logic                  pop_back;
		logic                  pop_front;
		logic [DATA_WIDTH-1:0] data;
	} cell_cmd_t;

	// what a cell shows its neighbours
	typedef struct packed {
		logic                  occ;
		logic [DATA_WIDTH-1:0] data;
	} cell_link_t;

endpackage

FILE: sv/deq_req_if.sv
// request channel: valid/ready handshake with request type and value
interface deq_req_if;
	import deq_pkg::*;

	logic                valid;
	logic                ready;
	req_type_t           req_type;
	logic [VALUE_W-1:0]  value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink   (input valid, input req_type, input value, output ready);
endinterface

FILE: sv/deq_rsp_if.sv
// response channel: valid/ready handshake with status, removed value and fill level
interface deq_rsp_if;
	import deq_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [VALUE_W-1:0]  out_value;
	logic [FILL_W-1:0]   fill_level;

	modport source (output valid, output status, output out_value, output fill_level,
		input ready);
	modport sink   (input valid, input status, input out_value, input fill_level,
		output ready);
endinterface

FILE: sv/deq_cell.sv
// one storage cell of the queue row: shifts with its neighbours on front operations
module deq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  deq_pkg::cell_cmd_t  cmd,
	input  deq_pkg::cell_link_t left,
	input  deq_pkg::cell_link_t right,
	output deq_pkg::cell_link_t link,
	output logic               tail
);
	import deq_pkg::*;

	logic                  occ_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  is_gap;

	// first empty slot behind the occupied run
	assign is_gap = !occ_q && left.occ;
	assign tail   = occ_q && !right.occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.push_front) begin
			occ_q <= left.occ;
		end else if (cmd.pop_front) begin
			occ_q <= right.occ;
		end else if (cmd.push_back && is_gap) begin
			occ_q <= 1'b1;
		end else if (cmd.pop_back && tail) begin
			occ_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= left.data;
		end else if (cmd.pop_front) begin
			data_q <= right.data;
		end else if (cmd.push_back && is_gap) begin
			data_q <= cmd.data;
		end
	end

	assign link.occ  = occ_q;
	assign link.data = data_q;
endmodule

FILE: sv/double_ended_queue_core.sv
// double-ended queue top level: request decode, row of cells and response register
//
// Usage: requests arrive on the req channel (req_type, value) and each one gives exactly
// one response on the rsp channel (status, out_value, fill_level). Elements sit in a row
// of DEPTH cells with the front element in cell 0; pushes and pops at the front shift the
// whole row by one cell at once, pushes and pops at the back touch only the cell
// at the end of the occupied run.
// Latency: the response is valid in the cycle after the request transfer.
// Throughput: one request per cycle; the single response register is the only limit, and
// req.ready stays high while that register is empty or being drained in the same cycle.
// A push on a full queue is dropped with status full; a pop on an empty queue returns
// status empty and zero.
// Reset: arst_n clears every cell occupancy bit, the fill count and the response valid,
// so the queue starts empty and takes requests as soon as reset is released.
// When the receiver stalls, the pending response holds and req.ready falls until it is
// taken; the queue contents do not change meanwhile.
module double_ended_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	deq_req_if.sink     req,
	deq_rsp_if.source   rsp
);
	import deq_pkg::*;

	cell_cmd_t            cmd;
	cell_link_t           links [DEPTH];
	cell_link_t           lefts [DEPTH];
	cell_link_t           rights [DEPTH];
	logic [DEPTH-1:0]     tails;
	logic [DEPTH-1:0]     occ_vec;
	logic                 accept;
	logic                 full;
	logic                 empty;
	logic                 ok;
	logic [DATA_WIDTH-1:0] back_value;
	logic [DATA_WIDTH-1:0] pop_value;
	status_t              status_d;
	logic [FILL_W-1:0]    count_d;
	logic [FILL_W-1:0]    count_q;
	logic                 rsp_valid_q;
	status_t              status_q;
	logic [VALUE_W-1:0]   out_value_q;
	logic [FILL_W-1:0]    fill_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = links[DEPTH-1].occ;
	assign empty     = !links[0].occ;

	always_comb begin
		cmd       = '0;
		cmd.data  = req.value[DATA_WIDTH-1:0];
		ok        = 1'b0;
		status_d  = STATUS_OK;
		count_d   = count_q;
		pop_value = '0;
		unique case (req.req_type) inside
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				ok = !full;
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					count_d = count_q + FILL_W'(1);
				end
			end
			REQ_POP_BACK, REQ_POP_FRONT: begin
				ok = !empty;
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					count_d   = count_q - FILL_W'(1);
					pop_value = (req.req_type == REQ_POP_BACK) ? back_value : links[0].data;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		cmd.push_back  = accept && ok && (req.req_type == REQ_PUSH_BACK);
		cmd.push_front = accept && ok && (req.req_type == REQ_PUSH_FRONT);
		cmd.pop_back   = accept && ok && (req.req_type == REQ_POP_BACK);
		cmd.pop_front  = accept && ok && (req.req_type == REQ_POP_FRONT);
	end

	// select the data of the last occupied cell
	always_comb begin
		back_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_value = back_value | ({DATA_WIDTH{tails[i]}} & links[i].data);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			// a push at the front enters through the left side of cell 0
			assign lefts[g].occ  = 1'b1;
			assign lefts[g].data = cmd.data;
		end else begin : g_mid
			assign lefts[g] = links[g-1];
		end
		if (g == DEPTH - 1) begin : g_end
			assign rights[g] = '0;
		end else begin : g_inner
			assign rights[g] = links[g+1];
		end

		deq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (lefts[g]),
			.right  (rights[g]),
			.link   (links[g]),
			.tail   (tails[g])
		);

		assign occ_vec[g] = links[g].occ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			out_value_q <= VALUE_W'(pop_value);
			fill_q      <= count_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.out_value  = out_value_q;
	assign rsp.fill_level = fill_q;

`ifndef ASSERT_OFF
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == 32'(count_q))
		else $error("fill count differs from occupied cells");

	a_cells_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_vec & (occ_vec + DEPTH'(1))) == '0)
		else $error("occupied cells do not form one run from cell 0");

	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q && (fill_q == count_q))
		else $error("response missing or fill level wrong after request transfer");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q) && $stable(occ_vec))
		else $error("queue changed without a request transfer");
`endif
endmodule

FILE: bench/tb.sv
// self-checking bench for the double-ended queue: directed and random requests checked against a shadow ring
module tb;
	import deq_pkg::*;

	localparam int unsigned TIMEOUT = 400000;

	typedef struct {
		req_type_t           kind;
		logic [VALUE_W-1:0]  value;
		int unsigned         gap;
		bit                  drain;
	} req_item_t;

	typedef struct packed {
		status_t             status;
		logic [VALUE_W-1:0]  out_value;
		logic [FILL_W-1:0]   fill_level;
	} deq_result_t;

	logic clk;
	logic arst_n;

	deq_req_if req_if();
	deq_rsp_if rsp_if();

	double_ended_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow queue, kept as a ring buffer
	logic [DATA_WIDTH-1:0] shadow_store [DEPTH];
	int unsigned           shadow_front;
	int unsigned           shadow_back;
	int unsigned           shadow_count;

	req_item_t   pending [$];
	deq_result_t rsp_expected [$];

	bit          req_taken;
	int unsigned rx_stall;
	int unsigned rx_phase;
	bit          rx_quiet;
	int unsigned cycles;
	int unsigned err_count;
	int unsigned n_sent;
	int unsigned n_rsp;
	int unsigned n_full;
	int unsigned n_empty;
	int unsigned peak_fill;

	always #5 clk = ~clk;

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// apply one request to the shadow queue and return the response it should give
	function automatic deq_result_t deque_apply(req_type_t kind, logic [VALUE_W-1:0] value);
		deq_result_t r;
		logic [DATA_WIDTH-1:0] data;
		data = value[DATA_WIDTH-1:0];
		r.status = STATUS_OK;
		r.out_value = '0;
		case (kind) inside
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = STATUS_FULL;
				end else if (kind == REQ_PUSH_BACK) begin
					shadow_store[shadow_back] = data;
					shadow_back = (shadow_back + 1) % DEPTH;
					shadow_count++;
				end else begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_store[shadow_front] = data;
					shadow_count++;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.status = STATUS_EMPTY;
				end else if (kind == REQ_POP_BACK) begin
					shadow_back = (shadow_back + DEPTH - 1) % DEPTH;
					r.out_value = VALUE_W'(shadow_store[shadow_back]);
					shadow_count--;
				end else begin
					r.out_value = VALUE_W'(shadow_store[shadow_front]);
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end
			end
		endcase
		r.fill_level = FILL_W'(shadow_count);
		if (shadow_count > peak_fill)
			peak_fill = shadow_count;
		return r;
	endfunction

	task automatic add_req(req_type_t kind, logic [VALUE_W-1:0] value, int unsigned gap,
		bit drain);
		req_item_t it;
		it.kind = kind;
		it.value = value;
		it.gap = gap;
		it.drain = drain;
		pending.push_back(it);
	endtask

	// request driver
	always @(negedge clk) begin
		logic send;
		req_item_t nxt;
		if (arst_n) begin
			send = req_if.valid && !req_taken;
			if (!send && pending.size() > 0) begin
				if (pending[0].gap > 0) begin
					pending[0].gap = pending[0].gap - 1;
				end else if (!pending[0].drain || rsp_expected.size() == 0) begin
					nxt = pending.pop_front();
					send = 1'b1;
					req_if.req_type <= nxt.kind;
					req_if.value <= nxt.value;
					n_sent++;
				end
			end
			req_if.valid <= send;
		end
	end

	// response ready: stalls of random length, with quiet stretches now and then
	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			rx_phase++;
			if (rx_phase % 256 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			rdy = 1'b1;
			if (rx_stall > 0) begin
				rdy = 1'b0;
				rx_stall--;
			end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
				rx_stall = idle_len();
				if (rx_stall > 0) begin
					rdy = 1'b0;
					rx_stall--;
				end
			end
			rsp_if.ready <= rdy;
		end
	end

	// monitor: predict on each request transfer, check each response transfer
	always @(posedge clk) begin
		deq_result_t want;
		if (arst_n) begin
			req_taken = req_if.valid && req_if.ready;
			if (rsp_if.valid && rsp_if.ready) begin
				n_rsp++;
				if (rsp_if.status == STATUS_FULL)
					n_full++;
				if (rsp_if.status == STATUS_EMPTY)
					n_empty++;
				if (rsp_expected.size() == 0) begin
					if (err_count < 10)
						$display("tb: cycle %0d: response with nothing outstanding", cycles);
					err_count++;
				end else begin
					want = rsp_expected.pop_front();
					if (rsp_if.status !== want.status || rsp_if.out_value !== want.out_value ||
						rsp_if.fill_level !== want.fill_level) begin
						if (err_count < 10)
							$display({"tb: cycle %0d: status %0d/%0d value %h/%h fill %0d/%0d",
								" (expected/actual)"}, cycles, want.status, rsp_if.status,
								want.out_value, rsp_if.out_value, want.fill_level,
								rsp_if.fill_level);
						err_count++;
					end
				end
			end
			if (req_taken)
				rsp_expected.push_back(deque_apply(req_if.req_type, req_if.value));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cycles >= TIMEOUT) begin
				$display("tb: timed out with %0d requests still queued", pending.size());
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		int unsigned total;
		int unsigned len;
		int unsigned bias;
		int unsigned r;
		bit quiet;
		bit first;
		req_type_t kind;
		logic [VALUE_W-1:0] v;

		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.req_type = REQ_PUSH_BACK;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
		shadow_front = 0;
		shadow_back = 0;
		shadow_count = 0;

		// directed: empty removals, value extremes, fill to the top with wrap, full inserts
		add_req(REQ_POP_BACK, '1, 0, 0);
		add_req(REQ_POP_FRONT, '1, 0, 0);
		add_req(REQ_PUSH_BACK, '0, 0, 0);
		add_req(REQ_POP_FRONT, '0, 0, 0);
		add_req(REQ_PUSH_FRONT, '1, 0, 0);
		add_req(REQ_POP_BACK, '0, 0, 0);
		for (int i = 0; i < DEPTH; i++)
			add_req((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
				(i % 3 == 0) ? '1 : VALUE_W'(32'h0101_0101 * i), 0, 0);
		add_req(REQ_PUSH_BACK, 32'hDEAD_BEEF, 0, 0);
		add_req(REQ_PUSH_FRONT, 32'hFEED_F00D, 0, 0);
		add_req(REQ_POP_FRONT, '0, 0, 0);
		add_req(REQ_POP_BACK, '0, 0, 0);

		// random: chunks biased towards filling, draining or neither
		total = 0;
		first = 1'b1;
		while (total < 1200) begin
			len = $urandom_range(20, 60);
			bias = $urandom_range(0, 2);
			quiet = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(0, 99);
				if ((bias == 0 && r < 75) || (bias == 1 && r < 25) || (bias == 2 && r < 50))
					kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
				else
					kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
				case ($urandom_range(0, 9))
					0: v = '0;
					1: v = '1;
					default: v = $urandom;
				endcase
				add_req(kind, v, quiet ? 0 : idle_len(),
					i == 0 && (first || $urandom_range(0, 5) == 0));
				first = 1'b0;
			end
			total += len;
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() > 0 || req_if.valid)
			@(posedge clk);
		while (rsp_expected.size() > 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("run: %0d requests, %0d responses, %0d mismatches, peak fill %0d of %0d",
			n_sent, n_rsp, err_count, peak_fill, DEPTH);
		$display("run: %0d inserts refused on a full queue, %0d removals from an empty one",
			n_full, n_empty);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
